[hw/rtl/bole_pkg.sv]
// Shared types and codes of the bounded ordered list engine.
// No dependencies; imported by every module of the block.
package bole_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int DUMP_MAX = 16;

    typedef enum logic [2:0] {
        CMD_PUSH_HEAD = 3'd0,
        CMD_PUSH_TAIL = 3'd1,
        CMD_SORTED    = 3'd2,
        CMD_SEARCH    = 3'd3,
        CMD_POP_HEAD  = 3'd4,
        CMD_POP_TAIL  = 3'd5,
        CMD_REMOVE    = 3'd6,
        CMD_DUMP      = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_POP,
        S_SHUP,
        S_INS,
        S_SHDN
    } t_state;

    typedef struct packed {
        logic              strb;
        t_status           status;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_result;

endpackage

[hw/rtl/bole_ram.sv]
// Entry store of the list: one write port, one read port, registered read data.
// Depends on bole_pkg for the data width.
module bole_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bole_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [bole_pkg::DATA_W-1:0] o_rdata
);
    import bole_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bole_ctrl.sv]
// Command sequencer: walks, shifts and updates the ring held in bole_ram.
// Depends on bole_pkg for command, status, state and result types.
module bole_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  bole_pkg::t_cmd              i_cmd,
    input  logic signed [bole_pkg::DATA_W-1:0] i_value,
    output logic                        o_busy,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [bole_pkg::DATA_W-1:0] o_wdata,
    output logic [AW-1:0]               o_raddr,
    input  logic [bole_pkg::DATA_W-1:0] i_rdata,
    output bole_pkg::t_result           o_res
);
    import bole_pkg::*;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW:0] off);
        logic [CW+1:0] sum;
        sum = (CW+2)'(head) + (CW+2)'(off);
        if (sum >= (CW+2)'(CAPACITY)) begin
            sum = sum - (CW+2)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [POS_W-1:0] f_pos(input logic [CW-1:0] k);
        logic [CW+POS_W-1:0] ext;
        ext = (CW+POS_W)'(k);
        return ext[POS_W-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    t_cmd                r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_p, n_p;
    t_result             r_res, n_res;

    logic          w_empty, w_full, w_k_last, w_dump_last, w_match;
    logic          w_lt_ev, w_lt_ve, w_sort_stop, w_shup_end, w_shdn_end;
    logic [CW-1:0] w_ins_p, w_k_inc;
    logic [AW-1:0] w_head_inc, w_head_dec;
    logic [CW+POS_W-1:0] w_k_ext;

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_k_inc     = r_k + CW'(1);
    assign w_k_last    = (w_k_inc == r_count);
    assign w_k_ext     = (CW+POS_W)'(r_k);
    assign w_dump_last = w_k_last || (w_k_ext == (CW+POS_W)'(DUMP_MAX - 1));
    assign w_match     = (i_rdata == r_value);
    assign w_lt_ev     = ($signed(i_rdata) < r_value);
    assign w_lt_ve     = (r_value < $signed(i_rdata));
    assign w_sort_stop = w_k_last || !w_lt_ev;
    assign w_ins_p     = w_lt_ve ? r_k : w_k_inc;
    assign w_shup_end  = (r_k == r_p + CW'(1));
    assign w_shdn_end  = ((CW+1)'(r_k) + (CW+1)'(2) == (CW+1)'(r_count));
    assign w_head_inc  = f_slot(r_head, (CW+1)'(1));
    assign w_head_dec  = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_SORTED: n_state = (w_full || w_empty) ? S_IDLE : S_WALK;
                        CMD_SEARCH, CMD_REMOVE, CMD_DUMP:
                            n_state = w_empty ? S_IDLE : S_WALK;
                        CMD_POP_HEAD, CMD_POP_TAIL:
                            n_state = w_empty ? S_IDLE : S_POP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                case (r_cmd)
                    CMD_SEARCH: begin
                        if (w_match || w_k_last) n_state = S_IDLE;
                    end
                    CMD_REMOVE: begin
                        if (w_match) begin
                            n_state = (r_k == '0 || w_k_last) ? S_IDLE : S_SHDN;
                        end else if (w_k_last) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_DUMP: begin
                        if (w_dump_last) n_state = S_IDLE;
                    end
                    CMD_SORTED: begin
                        if (w_sort_stop) begin
                            n_state = (w_ins_p == r_count) ? S_IDLE : S_SHUP;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POP:  n_state = S_IDLE;
            S_SHUP: n_state = w_shup_end ? S_INS : S_SHUP;
            S_INS:  n_state = S_IDLE;
            S_SHDN: n_state = w_shdn_end ? S_IDLE : S_SHDN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_cmd   = r_cmd;
        n_value = r_value;
        n_k     = r_k;
        n_p     = r_p;
        n_res   = '0;
        o_we    = 1'b0;
        o_waddr = r_head;
        o_wdata = r_value;
        o_raddr = r_head;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd      = i_cmd;
                    n_value    = i_value;
                    n_k        = '0;
                    n_res.strb = 1'b1;
                    n_res.last = 1'b1;
                    case (i_cmd)
                        CMD_PUSH_HEAD: begin
                            if (w_full) begin
                                n_res.status = STS_FULL;
                            end else begin
                                n_head  = w_head_dec;
                                o_we    = 1'b1;
                                o_waddr = w_head_dec;
                                o_wdata = i_value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_PUSH_TAIL: begin
                            if (w_full) begin
                                n_res.status = STS_FULL;
                            end else begin
                                o_we           = 1'b1;
                                o_waddr        = f_slot(r_head, (CW+1)'(r_count));
                                o_wdata        = i_value;
                                n_count        = r_count + CW'(1);
                                n_res.position = f_pos(r_count);
                            end
                        end
                        CMD_SORTED: begin
                            if (w_full) begin
                                n_res.status = STS_FULL;
                            end else if (w_empty) begin
                                o_we    = 1'b1;
                                o_waddr = r_head;
                                o_wdata = i_value;
                                n_count = CW'(1);
                            end else begin
                                n_res.strb = 1'b0;
                            end
                        end
                        CMD_SEARCH: begin
                            if (w_empty) n_res.status = STS_NOTFOUND;
                            else         n_res.strb   = 1'b0;
                        end
                        CMD_POP_HEAD: begin
                            n_p = '0;
                            if (w_empty) n_res.status = STS_EMPTY;
                            else         n_res.strb   = 1'b0;
                        end
                        CMD_POP_TAIL: begin
                            n_p     = r_count - CW'(1);
                            o_raddr = f_slot(r_head, (CW+1)'(r_count) - (CW+1)'(1));
                            if (w_empty) n_res.status = STS_EMPTY;
                            else         n_res.strb   = 1'b0;
                        end
                        default: begin
                            if (w_empty) n_res.status = STS_EMPTY;
                            else         n_res.strb   = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                o_raddr = f_slot(r_head, (CW+1)'(w_k_inc));
                n_k     = w_k_inc;
                case (r_cmd)
                    CMD_SEARCH: begin
                        if (w_match) begin
                            n_res.strb     = 1'b1;
                            n_res.last     = 1'b1;
                            n_res.data     = r_value;
                            n_res.position = f_pos(r_k);
                        end else if (w_k_last) begin
                            n_res.strb   = 1'b1;
                            n_res.last   = 1'b1;
                            n_res.status = STS_NOTFOUND;
                        end
                    end
                    CMD_REMOVE: begin
                        if (w_match) begin
                            n_res.strb     = 1'b1;
                            n_res.last     = 1'b1;
                            n_res.data     = i_rdata;
                            n_res.position = f_pos(r_k);
                            if (r_k == '0) begin
                                n_head  = (r_count == CW'(1)) ? '0 : w_head_inc;
                                n_count = r_count - CW'(1);
                            end else if (w_k_last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_k = r_k;
                            end
                        end else if (w_k_last) begin
                            n_res.strb   = 1'b1;
                            n_res.last   = 1'b1;
                            n_res.status = STS_NOTFOUND;
                        end
                    end
                    CMD_DUMP: begin
                        n_res.strb     = 1'b1;
                        n_res.last     = w_dump_last;
                        n_res.data     = i_rdata;
                        n_res.position = f_pos(r_k);
                    end
                    CMD_SORTED: begin
                        if (w_sort_stop) begin
                            n_res.strb     = 1'b1;
                            n_res.last     = 1'b1;
                            n_res.position = f_pos(w_ins_p);
                            n_p            = w_ins_p;
                            if (w_ins_p == r_count) begin
                                o_we    = 1'b1;
                                o_waddr = f_slot(r_head, (CW+1)'(r_count));
                                n_count = r_count + CW'(1);
                            end else begin
                                o_raddr = f_slot(r_head,
                                                 (CW+1)'(r_count) - (CW+1)'(1));
                                n_k     = r_count;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_POP: begin
                n_res.strb     = 1'b1;
                n_res.last     = 1'b1;
                n_res.data     = i_rdata;
                n_res.position = f_pos(r_p);
                n_count        = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_head = '0;
                end else if (r_cmd == CMD_POP_HEAD) begin
                    n_head = w_head_inc;
                end
            end
            S_SHUP: begin
                o_we    = 1'b1;
                o_waddr = f_slot(r_head, (CW+1)'(r_k));
                o_wdata = i_rdata;
                n_k     = r_k - CW'(1);
                if (!w_shup_end) begin
                    o_raddr = f_slot(r_head, (CW+1)'(r_k) - (CW+1)'(2));
                end
            end
            S_INS: begin
                o_we    = 1'b1;
                o_waddr = f_slot(r_head, (CW+1)'(r_p));
                n_count = r_count + CW'(1);
            end
            S_SHDN: begin
                o_we    = 1'b1;
                o_waddr = f_slot(r_head, (CW+1)'(r_k));
                o_wdata = i_rdata;
                n_k     = w_k_inc;
                if (w_shdn_end) begin
                    n_count = r_count - CW'(1);
                end else begin
                    o_raddr = f_slot(r_head, (CW+1)'(r_k) + (CW+1)'(2));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_value <= n_value;
        r_k     <= n_k;
        r_p     <= n_p;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

[hw/rtl/bounded_ordered_list_engine.sv]
// Bounded ordered list engine: up to CAPACITY signed 32-bit entries kept as a ring
// in one entry memory with a head index and a count. A command is taken when start
// is high and busy is low. Push head and push tail write the entry directly; pop
// head and pop tail first read the entry and then answer from the pop state. Search,
// remove value, sorted insert and dump read one entry per cycle through the single
// read port of the entry memory: remove value shifts the entries behind the match
// down at one per cycle once its walk stops, and sorted insert walks to its insert
// point and then shifts the entries behind it up at one per cycle before the final
// write of the new value. Each result is shown for one cycle on o_strb and must be
// taken then; the result is registered and appears in the cycle after the step that
// decides it. Dump gives one beat per cycle from head to tail, at most 16 beats, with
// o_last on the final beat. No clearing pass is needed after reset.
// Depends on bole_pkg, bole_ram and bole_ctrl.
module bounded_ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value,
    output logic               o_strb,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data,
    output logic [3:0]         o_position,
    output logic               o_last
);
    import bole_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    t_result           res;

    bole_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (t_cmd'(i_cmd)),
        .i_value (i_value),
        .o_busy  (busy),
        .o_we    (mem_we),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata),
        .o_res   (res)
    );

    bole_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_strb     = res.strb;
    assign o_status   = res.status;
    assign o_data     = $signed(res.data);
    assign o_position = res.position;
    assign o_last     = res.last;

endmodule

[hw/rtl/bole_chk.sv]
// Port-level checker for the bounded ordered list engine, bound to its top level.
// Depends on bole_pkg for status codes.
module bole_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         i_cmd,
    input logic signed [31:0] i_value,
    input logic               o_strb,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_data,
    input logic [3:0]         o_position,
    input logic               o_last
);
    import bole_pkg::*;

    a_stream_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strb && !o_last |=> o_strb)
        else $error("dump stream broke before its last beat");

    a_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strb && !o_last |-> busy)
        else $error("engine idle while a dump is still in flight");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strb && o_status != STS_OK |-> o_data == 32'sd0 && o_position == 4'd0 && o_last)
        else $error("error beat carries payload or is not final");

    a_cmd_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strb)
        else $error("accepted command neither busy nor answered");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strb |-> $past(busy) || $past(start))
        else $error("result beat without a command");

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (.*);

[tb/bounded_ordered_list_engine_tb.sv]
// Self-checking testbench for bounded_ordered_list_engine: list commands go in, and every
// strobed beat is compared with a queue-based prediction of the list. Uses bole_pkg codes.
// Directed corner commands run first, then random fill, drain and mixed runs with gaps.
module bounded_ordered_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bole_pkg::*;

    localparam int LIST_CAP     = 16;
    localparam int RANDOM_ITEMS = 240;
    localparam int QUIET_TAIL   = 40;
    localparam int DRAIN_CYCLES = 64;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        t_status            status;
        logic signed [31:0] data;
        logic [3:0]         position;
        logic               is_last;
    } t_list_beat;

    class list_tracker;
        logic signed [31:0] contents[$];
        t_list_beat         awaited[$];
        int                 mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void add_beat(t_status st, logic signed [31:0] d, int pos, logic lst);
            t_list_beat b;
            b.status   = st;
            b.data     = d;
            b.position = pos[3:0];
            b.is_last  = lst;
            awaited.push_back(b);
        endfunction

        function int find_first(logic signed [31:0] value);
            for (int k = 0; k < contents.size(); k++) begin
                if (contents[k] == value) return k;
            end
            return contents.size();
        endfunction

        function void note_command(t_cmd cmd, logic signed [31:0] value);
            int                 p;
            int                 n;
            logic signed [31:0] d;
            n = contents.size();
            case (cmd)
                CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_SORTED: begin
                    if (n >= LIST_CAP) begin
                        add_beat(STS_FULL, 0, 0, 1'b1);
                    end else begin
                        if (cmd == CMD_PUSH_HEAD) begin
                            p = 0;
                        end else if (cmd == CMD_PUSH_TAIL || n == 0) begin
                            p = n;
                        end else begin
                            // stop at first entry not below value; go after it unless greater
                            p = 0;
                            while (p + 1 < n && contents[p] < value) p++;
                            if (!(value < contents[p])) p++;
                        end
                        contents.insert(p, value);
                        add_beat(STS_OK, 0, p, 1'b1);
                    end
                end
                CMD_SEARCH: begin
                    p = find_first(value);
                    if (p >= n) add_beat(STS_NOTFOUND, 0, 0, 1'b1);
                    else add_beat(STS_OK, value, p, 1'b1);
                end
                CMD_POP_HEAD, CMD_POP_TAIL, CMD_REMOVE: begin
                    if (n == 0) begin
                        add_beat(STS_EMPTY, 0, 0, 1'b1);
                    end else begin
                        if (cmd == CMD_POP_HEAD) p = 0;
                        else if (cmd == CMD_POP_TAIL) p = n - 1;
                        else p = find_first(value);
                        if (p >= n) begin
                            add_beat(STS_NOTFOUND, 0, 0, 1'b1);
                        end else begin
                            d = contents[p];
                            contents.delete(p);
                            add_beat(STS_OK, d, p, 1'b1);
                        end
                    end
                end
                CMD_DUMP: begin
                    if (n == 0) begin
                        add_beat(STS_EMPTY, 0, 0, 1'b1);
                    end else begin
                        for (int k = 0; k < n && k < DUMP_MAX; k++) begin
                            add_beat(STS_OK, contents[k], k,
                                     (k + 1 == n) || (k + 1 == DUMP_MAX));
                        end
                    end
                end
            endcase
        endfunction

        function void check_beat(logic [1:0] st, logic signed [31:0] d, logic [3:0] pos,
                                 logic lst);
            t_list_beat e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d data %0d position %0d last %0b",
                             st, d, pos, lst);
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status || d !== e.data || pos !== e.position ||
                lst !== e.is_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"beat mismatch: expected status %0d data %0d position %0d",
                              " last %0b, got status %0d data %0d position %0d last %0b"},
                             e.status, e.data, e.position, e.is_last, st, d, pos, lst);
            end
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    logic [2:0]         i_cmd   = CMD_PUSH_HEAD;
    logic signed [31:0] i_value = '0;
    logic               o_strb;
    logic [1:0]         o_status;
    logic signed [31:0] o_data;
    logic [3:0]         o_position;
    logic               o_last;

    list_tracker tracker = new();
    int          random_sent = 0;

    bounded_ordered_list_engine #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .i_value   (i_value),
        .o_strb    (o_strb),
        .o_status  (o_status),
        .o_data    (o_data),
        .o_position(o_position),
        .o_last    (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strb) tracker.check_beat(o_status, o_data, o_position, o_last);
    end

    // hold the beat until busy is low at a rising edge; return at the next falling edge
    task automatic send_command(t_cmd cmd, logic signed [31:0] value);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_command(cmd, value);
        @(negedge i_clk);
    endtask

    task automatic issue(t_cmd cmd, logic signed [31:0] value);
        send_command(cmd, value);
        if (random_sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (tracker.awaited.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            3, 4, 5: return int'($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] stored_value();
        int n;
        n = tracker.contents.size();
        if (n != 0 && $urandom_range(0, 9) < 7)
            return tracker.contents[$urandom_range(0, n - 1)];
        return any_value();
    endfunction

    task automatic send_random(t_cmd cmd);
        logic signed [31:0] v;
        if (cmd == CMD_SEARCH || cmd == CMD_REMOVE) v = stored_value();
        else v = any_value();
        random_sent++;
        issue(cmd, v);
    endtask

    task automatic fill_run();
        while (tracker.contents.size() < LIST_CAP) begin
            if ($urandom_range(0, 4) == 0) send_random(CMD_SEARCH);
            else send_random(t_cmd'($urandom_range(0, 2)));
        end
        repeat ($urandom_range(1, 2)) send_random(t_cmd'($urandom_range(0, 2)));
        send_random(CMD_DUMP);
    endtask

    task automatic drain_run();
        while (tracker.contents.size() != 0) send_random(t_cmd'($urandom_range(4, 6)));
        send_random(t_cmd'($urandom_range(4, 6)));
        send_random(CMD_DUMP);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(CMD_DUMP, 0);
        issue(CMD_POP_HEAD, VAL_MAX);
        issue(CMD_POP_TAIL, VAL_MIN);
        issue(CMD_REMOVE, 5);
        issue(CMD_SEARCH, 5);
        issue(CMD_SORTED, 0);
        issue(CMD_PUSH_HEAD, VAL_MIN);
        issue(CMD_PUSH_TAIL, VAL_MAX);
        issue(CMD_SORTED, -1);
        issue(CMD_SORTED, 0);
        issue(CMD_SORTED, VAL_MAX);
        issue(CMD_SORTED, VAL_MIN);
        issue(CMD_SORTED, 1);
        issue(CMD_SEARCH, 0);
        issue(CMD_SEARCH, 42);
        issue(CMD_REMOVE, 42);
        issue(CMD_REMOVE, -1);
        issue(CMD_DUMP, -1);
        issue(CMD_POP_HEAD, 0);
        issue(CMD_POP_TAIL, 0);
        issue(CMD_REMOVE, 0);
        wait_drained();

        fill_run();
        drain_run();
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       fill_run();
                1:       drain_run();
                default: repeat (20) send_random(t_cmd'($urandom_range(0, 7)));
            endcase
        end

        wait_drained();
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
            $display("[bounded_ordered_list_engine] OK");
        end else begin
            $display("[bounded_ordered_list_engine] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[bounded_ordered_list_engine] ERROR");
        $finish;
    end

endmodule
